>>> rtl/ptmm_pkg.sv
// ----------------------------------------------------------------------------
// ptmm_pkg
// Shared types, constants and character helpers of the plate text mask matcher.
// ----------------------------------------------------------------------------
package ptmm_pkg;

   localparam int unsigned MASK_W      = 6;
   localparam int unsigned CHAR_W      = 8;
   localparam int unsigned FMT_OUT_W   = 3;
   localparam int unsigned SCORE_OUT_W = 3;

   localparam logic [CHAR_W-1:0] CHAR_UNDERSCORE = 8'h5F;
   localparam logic [CHAR_W-1:0] CHAR_NONE       = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_A    = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_Z    = 8'h7A;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_A    = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_Z    = 8'h5A;
   localparam logic [CHAR_W-1:0] CHAR_DIGIT_0    = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_DIGIT_9    = 8'h39;
   localparam logic [CHAR_W-1:0] CASE_OFFSET     = 8'h20;

   typedef struct packed {
      logic take;
      logic miss;
      logic score;
      logic emit;
   } ptmm_cmd_type;

   typedef struct packed {
      logic full_after;
      logic fmt_last;
      logic pos_last;
   } ptmm_status_type;

   function automatic logic [MASK_W-1:0] mask_reset_value(input int unsigned k);
      logic [MASK_W-1:0] v;
      v = '0;
      unique case (k)
         0:       v = 6'd7;
         1:       v = 6'd56;
         2:       v = 6'd57;
         3:       v = 6'd39;
         4:       v = 6'd60;
         default: v = '0;
      endcase
      return v;
   endfunction

   function automatic logic is_letter(input logic [CHAR_W-1:0] c);
      return (c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z);
   endfunction

   function automatic logic is_digit(input logic [CHAR_W-1:0] c);
      return (c >= CHAR_DIGIT_0) && (c <= CHAR_DIGIT_9);
   endfunction

   function automatic logic [CHAR_W-1:0] to_upper(input logic [CHAR_W-1:0] c);
      return ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z)) ? c - CASE_OFFSET : c;
   endfunction

   function automatic logic class_fits(input logic [CHAR_W-1:0] c, input logic want_letter);
      return want_letter ? is_letter(c) : is_digit(c);
   endfunction

endpackage

>>> rtl/ptmm_ctrl.sv
// ----------------------------------------------------------------------------
// ptmm_ctrl
// Sequencer: collects bytes, steps the format scorer, then steps the output.
// ----------------------------------------------------------------------------
module ptmm_ctrl
   import ptmm_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic            req_text_end,
   input  ptmm_status_type status,
   output ptmm_cmd_type    cmd,
   output logic            busy
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SCORE = 3'b010,
      ST_EMIT  = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      busy      = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.take = start;
            cmd.miss = start && req_text_end && !status.full_after;
            if (start && req_text_end && status.full_after) begin
               state_in = ST_SCORE;
            end
         end
         ST_SCORE: begin
            cmd.score = 1'b1;
            if (status.fmt_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            if (status.pos_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_miss_stays_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.miss |=> !busy)
      else $error("short string left the idle state");

   a_busy_ends_on_emit: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(busy)) |-> $past(cmd.emit && status.pos_last))
      else $error("busy dropped before the last character transfer");

endmodule

>>> rtl/ptmm_datapath.sv
// ----------------------------------------------------------------------------
// ptmm_datapath
// Character store, mask registers, shared format scorer and result register.
// ----------------------------------------------------------------------------
module ptmm_datapath
   import ptmm_pkg::*;
#(
   parameter int unsigned PLATE_CHARS  = 6,
   parameter int unsigned FORMAT_COUNT = 5,
   localparam int unsigned IDX_W   = (PLATE_CHARS > 1) ? $clog2(PLATE_CHARS) : 1,
   localparam int unsigned CNT_W   = $clog2(PLATE_CHARS + 1),
   localparam int unsigned FMT_W   = (FORMAT_COUNT > 1) ? $clog2(FORMAT_COUNT) : 1,
   localparam int unsigned SCORE_W = $clog2(PLATE_CHARS + 1)
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  ptmm_cmd_type           cmd,
   output ptmm_status_type        status,
   input  logic                   csr_wr_en,
   input  logic [FMT_W-1:0]       csr_index,
   input  logic [MASK_W-1:0]      csr_wr_data,
   input  logic [CHAR_W-1:0]      req_text_byte,
   output logic                   rsp_valid,
   output logic [CHAR_W-1:0]      rsp_plate_char,
   output logic                   rsp_plate_found,
   output logic [FMT_OUT_W-1:0]   rsp_best_format,
   output logic [SCORE_OUT_W-1:0] rsp_match_score,
   output logic                   rsp_run_last
);

   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(PLATE_CHARS);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PLATE_CHARS - 1);
   localparam logic [IDX_W-1:0] POS_LAST = IDX_W'(PLATE_CHARS - 1);
   localparam logic [FMT_W-1:0] FMT_LAST = FMT_W'(FORMAT_COUNT - 1);

   logic [MASK_W-1:0]      mask_ff [FORMAT_COUNT];
   logic [CHAR_W-1:0]      kept_ff [PLATE_CHARS];
   logic [CNT_W-1:0]       kept_count_ff;
   logic [CNT_W-1:0]       kept_count_in;
   logic [FMT_W-1:0]       fmt_ff;
   logic [IDX_W-1:0]       pos_ff;
   logic [FMT_W-1:0]       best_ff;
   logic [SCORE_W-1:0]     best_score_ff;
   logic [PLATE_CHARS-1:0] best_want_ff;

   logic                   rsp_valid_ff;
   logic [CHAR_W-1:0]      rsp_char_ff;
   logic                   rsp_found_ff;
   logic [FMT_OUT_W-1:0]   rsp_fmt_ff;
   logic [SCORE_OUT_W-1:0] rsp_score_ff;
   logic                   rsp_last_ff;

   logic [CHAR_W-1:0]      byte_upper;
   logic                   byte_ok;
   logic                   store_byte;
   logic [PLATE_CHARS-1:0] want_vec;
   logic [SCORE_W-1:0]     fmt_score;
   logic                   take_best;
   logic [CHAR_W-1:0]      emit_char;
   logic                   emit_fits;

   assign byte_upper = to_upper(req_text_byte);
   assign byte_ok    = is_letter(byte_upper) || is_digit(byte_upper);
   assign store_byte = cmd.take && byte_ok && (kept_count_ff < CNT_FULL);

   assign status.full_after = (kept_count_ff == CNT_FULL)
                           || ((kept_count_ff == CNT_LAST) && byte_ok);
   assign status.fmt_last   = (fmt_ff == FMT_LAST);
   assign status.pos_last   = (pos_ff == POS_LAST);

   assign want_vec = PLATE_CHARS'(mask_ff[fmt_ff]);

   always_comb begin
      fmt_score = '0;
      for (int i = 0; i < PLATE_CHARS; i++) begin
         fmt_score = fmt_score + SCORE_W'(class_fits(kept_ff[i], want_vec[i]));
      end
   end

   assign take_best = (fmt_ff == '0) || (fmt_score > best_score_ff);
   assign emit_char = kept_ff[pos_ff];
   assign emit_fits = class_fits(emit_char, best_want_ff[pos_ff]);

   always_comb begin
      kept_count_in = kept_count_ff;
      priority if (cmd.miss || (cmd.emit && status.pos_last)) begin
         kept_count_in = '0;
      end else if (store_byte) begin
         kept_count_in = kept_count_ff + 1'b1;
      end else begin
         kept_count_in = kept_count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kept_count_ff <= '0;
         fmt_ff        <= '0;
         pos_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         for (int k = 0; k < FORMAT_COUNT; k++) begin
            mask_ff[k] <= mask_reset_value(k);
         end
      end else begin
         kept_count_ff <= kept_count_in;
         fmt_ff        <= cmd.score ? fmt_ff + 1'b1 : '0;
         pos_ff        <= cmd.emit ? pos_ff + 1'b1 : '0;
         rsp_valid_ff  <= cmd.miss || cmd.emit;
         if (csr_wr_en && ({1'b0, csr_index} < (FMT_W + 1)'(FORMAT_COUNT))) begin
            mask_ff[csr_index] <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (store_byte) begin
         kept_ff[kept_count_ff[IDX_W-1:0]] <= byte_upper;
      end
      if (cmd.score && take_best) begin
         best_ff       <= fmt_ff;
         best_score_ff <= fmt_score;
         best_want_ff  <= want_vec;
      end
      if (cmd.miss) begin
         rsp_char_ff  <= CHAR_NONE;
         rsp_found_ff <= 1'b0;
         rsp_fmt_ff   <= '0;
         rsp_score_ff <= '0;
         rsp_last_ff  <= 1'b1;
      end else if (cmd.emit) begin
         rsp_char_ff  <= emit_fits ? emit_char : CHAR_UNDERSCORE;
         rsp_found_ff <= 1'b1;
         rsp_fmt_ff   <= FMT_OUT_W'(best_ff);
         rsp_score_ff <= SCORE_OUT_W'(best_score_ff);
         rsp_last_ff  <= status.pos_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_plate_char  = rsp_char_ff;
   assign rsp_plate_found = rsp_found_ff;
   assign rsp_best_format = rsp_fmt_ff;
   assign rsp_match_score = rsp_score_ff;
   assign rsp_run_last    = rsp_last_ff;

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      kept_count_ff <= CNT_FULL)
      else $error("kept character count overran the plate length");

   a_emit_needs_full: assert property (@(posedge clock) disable iff (reset)
      (cmd.score || cmd.emit) |-> (kept_count_ff == CNT_FULL))
      else $error("scoring or output started without a full plate");

   a_miss_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_found_ff) |-> rsp_last_ff)
      else $error("not-found transfer without the last flag");

endmodule

>>> rtl/plate_text_mask_matcher.sv
// ----------------------------------------------------------------------------
// plate_text_mask_matcher
// Filters a text stream to plate characters and matches them to format masks.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle while busy is low (start high, busy low).
// A byte that is not the last of its string causes no result. On a last byte
// with fewer than PLATE_CHARS letters or digits kept, one not-found result
// appears on the cycle after the transfer and busy stays low. Otherwise busy
// rises while the shared scorer steps through the formats in turn and then while
// the output characters go out in turn. Results are one-cycle pulses of
// rsp_valid, back to back, the first one registered from the first output step
// after scoring; the receiver cannot stall them. Write the mask registers only
// while busy is low and no result is pending.
// ----------------------------------------------------------------------------
module plate_text_mask_matcher
   import ptmm_pkg::*;
#(
   parameter int unsigned PLATE_CHARS  = 6,
   parameter int unsigned FORMAT_COUNT = 5,
   localparam int unsigned FMT_W = (FORMAT_COUNT > 1) ? $clog2(FORMAT_COUNT) : 1
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [CHAR_W-1:0]      req_text_byte,
   input  logic                   req_text_end,
   output logic                   rsp_valid,
   output logic [CHAR_W-1:0]      rsp_plate_char,
   output logic                   rsp_plate_found,
   output logic [FMT_OUT_W-1:0]   rsp_best_format,
   output logic [SCORE_OUT_W-1:0] rsp_match_score,
   output logic                   rsp_run_last,
   input  logic                   csr_wr_en,
   input  logic [FMT_W-1:0]       csr_index,
   input  logic [MASK_W-1:0]      csr_wr_data
);

   ptmm_cmd_type    cmd;
   ptmm_status_type status;

   ptmm_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .req_text_end (req_text_end),
      .status       (status),
      .cmd          (cmd),
      .busy         (busy)
   );

   ptmm_datapath #(
      .PLATE_CHARS  (PLATE_CHARS),
      .FORMAT_COUNT (FORMAT_COUNT)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data),
      .req_text_byte   (req_text_byte),
      .rsp_valid       (rsp_valid),
      .rsp_plate_char  (rsp_plate_char),
      .rsp_plate_found (rsp_plate_found),
      .rsp_best_format (rsp_best_format),
      .rsp_match_score (rsp_match_score),
      .rsp_run_last    (rsp_run_last)
   );

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the plate text mask matcher.
// ----------------------------------------------------------------------------
// Text strings are fed one byte per transfer from a pending queue. Each
// accepted byte is folded into a local plate predictor that keeps the first
// six letters or digits and scores them against its own copy of the five
// format masks. The predictor queues the expected plate results, and the
// monitor checks every result strobe against the oldest one. Three phases run
// with different mask settings (reset values, extremes, random) and
// different sender idling. Strings are mostly well-formed plates with random
// content, plus short, noisy and raw random strings.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ptmm_pkg::*;

   localparam int PLATE_LEN     = 6;
   localparam int FMT_REGS      = 5;
   localparam int CSR_SLOTS     = 8;
   localparam int PHASE_BYTES   = 61;
   localparam int SETTLE_CYCLES = 16;
   localparam int STALL_LIMIT   = 4000;
   localparam int MAX_REPORTS   = 10;

   typedef struct packed {
      logic [CHAR_W-1:0] text;
      logic              tail;
   } text_item_type;

   typedef struct packed {
      logic [CHAR_W-1:0]      ch;
      logic                   found;
      logic [FMT_OUT_W-1:0]   fmt;
      logic [SCORE_OUT_W-1:0] score;
      logic                   last;
   } plate_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic [CHAR_W-1:0]      req_text_byte = '0;
   logic                   req_text_end = 1'b0;
   logic                   rsp_valid;
   logic [CHAR_W-1:0]      rsp_plate_char;
   logic                   rsp_plate_found;
   logic [FMT_OUT_W-1:0]   rsp_best_format;
   logic [SCORE_OUT_W-1:0] rsp_match_score;
   logic                   rsp_run_last;
   logic                   csr_wr_en = 1'b0;
   logic [2:0]             csr_index = '0;
   logic [MASK_W-1:0]      csr_wr_data = '0;

   text_item_type    text_queue[$];
   plate_result_type plate_expect_q[$];

   logic [MASK_W-1:0] fmt_masks[FMT_REGS];
   logic [CHAR_W-1:0] kept_text[PLATE_LEN];
   int                kept_num = 0;

   int idle_pct = 0;
   int bytes_sent = 0;
   int strings_sent = 0;
   int results_seen = 0;
   int mismatches = 0;
   int stall_cycles = 0;

   plate_text_mask_matcher DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_text_byte   (req_text_byte),
      .req_text_end    (req_text_end),
      .rsp_valid       (rsp_valid),
      .rsp_plate_char  (rsp_plate_char),
      .rsp_plate_found (rsp_plate_found),
      .rsp_best_format (rsp_best_format),
      .rsp_match_score (rsp_match_score),
      .rsp_run_last    (rsp_run_last),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
      if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
         return c - CASE_OFFSET;
      end
      return c;
   endfunction

   function automatic logic upper_letter(input logic [CHAR_W-1:0] c);
      return c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z;
   endfunction

   function automatic logic decimal_digit(input logic [CHAR_W-1:0] c);
      return c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9;
   endfunction

   function automatic logic slot_fits(input logic [CHAR_W-1:0] c, input logic want_letter);
      return want_letter ? upper_letter(c) : decimal_digit(c);
   endfunction

   // Fold one accepted byte into the plate state; queue results on a last byte.
   function automatic void absorb_text(input logic [CHAR_W-1:0] raw, input logic tail);
      logic [CHAR_W-1:0] c;
      plate_result_type  r;
      int                best_fmt;
      int                best_pts;
      int                pts;
      c = fold_case(raw);
      if ((upper_letter(c) || decimal_digit(c)) && kept_num < PLATE_LEN) begin
         kept_text[kept_num] = c;
         kept_num++;
      end
      if (!tail) begin
         return;
      end
      if (kept_num < PLATE_LEN) begin
         r.ch    = CHAR_NONE;
         r.found = 1'b0;
         r.fmt   = '0;
         r.score = '0;
         r.last  = 1'b1;
         plate_expect_q.push_back(r);
         kept_num = 0;
         return;
      end
      best_fmt = 0;
      best_pts = -1;
      for (int k = 0; k < FMT_REGS; k++) begin
         pts = 0;
         for (int i = 0; i < PLATE_LEN; i++) begin
            if (slot_fits(kept_text[i], fmt_masks[k][i])) begin
               pts++;
            end
         end
         if (pts > best_pts) begin
            best_pts = pts;
            best_fmt = k;
         end
      end
      for (int i = 0; i < PLATE_LEN; i++) begin
         r.ch    = slot_fits(kept_text[i], fmt_masks[best_fmt][i]) ? kept_text[i]
                                                                   : CHAR_UNDERSCORE;
         r.found = 1'b1;
         r.fmt   = FMT_OUT_W'(best_fmt);
         r.score = SCORE_OUT_W'(best_pts);
         r.last  = (i == PLATE_LEN - 1);
         plate_expect_q.push_back(r);
      end
      kept_num = 0;
   endfunction

   function automatic logic [CHAR_W-1:0] letter_byte();
      return CHAR_W'($urandom_range(25)) + (($urandom_range(1) != 0) ? CHAR_UPPER_A
                                                                   : CHAR_LOWER_A);
   endfunction

   function automatic logic [CHAR_W-1:0] digit_byte();
      return CHAR_DIGIT_0 + CHAR_W'($urandom_range(9));
   endfunction

   function automatic logic [CHAR_W-1:0] noise_byte();
      logic [CHAR_W-1:0] c;
      do begin
         c = CHAR_W'($urandom);
      end while (upper_letter(fold_case(c)) || decimal_digit(c));
      return c;
   endfunction

   task automatic push_text(input logic [CHAR_W-1:0] c, input logic tail);
      text_queue.push_back({c, tail});
   endtask

   task automatic queue_directed();
      // case-fold edges and their neighbors; only four kept, so no plate
      push_text(8'h61, 1'b0);
      push_text(8'h7A, 1'b0);
      push_text(8'h60, 1'b0);
      push_text(8'h7B, 1'b0);
      push_text(8'h30, 1'b0);
      push_text(8'h39, 1'b0);
      push_text(8'h2F, 1'b0);
      push_text(8'h3A, 1'b1);
      // byte extremes, then a plate with one surplus character
      push_text(8'h00, 1'b0);
      push_text(8'hFF, 1'b0);
      push_text(8'h40, 1'b0);
      push_text(8'h5B, 1'b0);
      push_text(8'h78, 1'b0);
      push_text(8'h31, 1'b0);
      push_text(8'h32, 1'b0);
      push_text(8'h33, 1'b0);
      push_text(8'h79, 1'b0);
      push_text(8'h7A, 1'b0);
      push_text(8'h77, 1'b1);
      // all letters: three formats tie, lowest index wins
      push_text(8'h41, 1'b0);
      push_text(8'h62, 1'b0);
      push_text(8'h63, 1'b0);
      push_text(8'h64, 1'b0);
      push_text(8'h65, 1'b0);
      push_text(8'h5A, 1'b1);
      // nothing kept at all
      push_text(8'hFF, 1'b1);
   endtask

   task automatic queue_random_strings(input int budget);
      text_item_type     part[$];
      logic [MASK_W-1:0] pat;
      logic              want_letter;
      int                made;
      int                kind;
      int                extra;
      int                goal;
      made = 0;
      while (made < budget) begin
         part.delete();
         kind = $urandom_range(99);
         if (kind < 78) begin
            pat   = ($urandom_range(1) != 0) ? fmt_masks[$urandom_range(FMT_REGS - 1)]
                                             : MASK_W'($urandom);
            extra = ($urandom_range(3) == 0) ? $urandom_range(3, 1) : 0;
            for (int i = 0; i < PLATE_LEN + extra; i++) begin
               if ($urandom_range(4) == 0) begin
                  part.push_back({noise_byte(), 1'b0});
               end
               want_letter = (i < PLATE_LEN) ? pat[i] : ($urandom_range(1) != 0);
               if ($urandom_range(6) == 0) begin
                  want_letter = !want_letter;
               end
               part.push_back({want_letter ? letter_byte() : digit_byte(), 1'b0});
            end
         end else if (kind < 92) begin
            goal = $urandom_range(PLATE_LEN - 1);
            for (int i = 0; i < goal; i++) begin
               if ($urandom_range(2) == 0) begin
                  part.push_back({noise_byte(), 1'b0});
               end
               part.push_back({($urandom_range(1) != 0) ? letter_byte() : digit_byte(),
                               1'b0});
            end
            if (part.size() == 0 || $urandom_range(1) != 0) begin
               part.push_back({noise_byte(), 1'b0});
            end
         end else begin
            goal = $urandom_range(10, 1);
            for (int i = 0; i < goal; i++) begin
               part.push_back({CHAR_W'($urandom), 1'b0});
            end
         end
         part[part.size() - 1].tail = 1'b1;
         made += part.size();
         foreach (part[i]) begin
            text_queue.push_back(part[i]);
         end
      end
   endtask

   task automatic write_mask(input int slot, input logic [MASK_W-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= 3'(slot);
      csr_wr_data <= value;
      if (slot < FMT_REGS) begin
         fmt_masks[slot] = value;
      end
   endtask

   task automatic end_writes();
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic settle();
      while (text_queue.size() != 0 || start || plate_expect_q.size() != 0 || busy) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic flag_result(input logic unexpected, input plate_result_type want,
                              input plate_result_type got);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         if (unexpected) begin
            $display("ERROR: unexpected result char %h found %b fmt %0d score %0d last %b",
                     got.ch, got.found, got.fmt, got.score, got.last);
         end else begin
            $display("ERROR: expected char %h found %b fmt %0d score %0d last %b",
                     want.ch, want.found, want.fmt, want.score, want.last);
            $display("       got      char %h found %b fmt %0d score %0d last %b",
                     got.ch, got.found, got.fmt, got.score, got.last);
         end
      end
   endtask

   always @(posedge clock) begin : text_driver
      logic taken;
      taken = start && !busy;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (taken) begin
            absorb_text(req_text_byte, req_text_end);
            void'(text_queue.pop_front());
            bytes_sent++;
            if (req_text_end) begin
               strings_sent++;
            end
         end
         // hold an offered byte until the transfer happens
         if (!start || taken) begin
            if (text_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
               start         <= 1'b1;
               req_text_byte <= text_queue[0].text;
               req_text_end  <= text_queue[0].tail;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : plate_monitor
      plate_result_type got;
      plate_result_type want;
      if (!reset && rsp_valid) begin
         got.ch    = rsp_plate_char;
         got.found = rsp_plate_found;
         got.fmt   = rsp_best_format;
         got.score = rsp_match_score;
         got.last  = rsp_run_last;
         results_seen++;
         if (plate_expect_q.size() == 0) begin
            flag_result(1'b1, got, got);
         end else begin
            want = plate_expect_q.pop_front();
            if (got !== want) begin
               flag_result(1'b0, want, got);
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
         $display("Mismatches found");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      fmt_masks[0] = 6'd7;
      fmt_masks[1] = 6'd56;
      fmt_masks[2] = 6'd57;
      fmt_masks[3] = 6'd39;
      fmt_masks[4] = 6'd60;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      idle_pct = 0;
      queue_directed();
      queue_random_strings(PHASE_BYTES);
      settle();

      write_mask(0, 6'h00);
      write_mask(1, 6'h3F);
      write_mask(2, 6'h2A);
      write_mask(3, 6'h15);
      write_mask(4, 6'h3F);
      write_mask(5, 6'h3F);
      write_mask(6, 6'h00);
      write_mask(CSR_SLOTS - 1, MASK_W'($urandom));
      end_writes();
      idle_pct = 77;
      queue_random_strings(PHASE_BYTES);
      settle();

      for (int k = 0; k < CSR_SLOTS; k++) begin
         write_mask(k, MASK_W'($urandom));
      end
      end_writes();
      idle_pct = 23;
      queue_random_strings(PHASE_BYTES);
      settle();

      $display("Fed %0d text bytes in %0d strings, checked %0d plate results", bytes_sent,
               strings_sent, results_seen);
      $display("Mask sets: reset, extremes, random; sender idling 0, 77 and 23 percent");
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/ptmm_pkg.sv
rtl/ptmm_ctrl.sv
rtl/ptmm_datapath.sv
rtl/plate_text_mask_matcher.sv
bench/tb_top.sv
